// ----- rtl/core/lpht_pkg.sv -----
`timescale 1ns / 1ps
package lpht_pkg;

   typedef enum logic [2:0] {
      MODE_LOOKUP     = 3'd0,
      MODE_ENTER      = 3'd1,
      MODE_REMOVE     = 3'd2,
      MODE_ITER_FIRST = 3'd3,
      MODE_ITER_NEXT  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_FULL     = 3'd5,
      ST_END      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_FETCH,
      S_OUT
   } state_type;

   localparam int MODE_BITS    = 3;
   localparam int STATUS_BITS  = 3;
   localparam int HASH_BITS    = 32;
   localparam int IN_KEY_BITS  = 32;
   localparam int IN_DATA_BITS = 32;
   localparam int SLOT_BITS    = 8;
   localparam int COUNT_BITS   = 9;
   localparam int LOAD_BITS    = 7;
   localparam logic [LOAD_BITS-1:0] LOAD_RESET   = 7'd70;
   localparam logic [LOAD_BITS-1:0] LOAD_CEILING = 7'd99;
   localparam int PERCENT      = 100;
   localparam logic [HASH_BITS-1:0] TAG_EMPTY = 32'd0;
   localparam logic [HASH_BITS-1:0] TAG_TOMB  = 32'd1;
   localparam logic [HASH_BITS-1:0] HASH_TOP  = 32'h8000_0000;

endpackage

// ----- rtl/core/lpht_ram.sv -----
`timescale 1ns / 1ps
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/linear_probe_hash_table_core.sv -----
`timescale 1ns / 1ps
// open-addressing hash table with linear probing, keys/data in on-chip ram
// req channel: tuser = mode, tdata = {data_in, hash_in, key_in} (key_in lowest)
// rsp channel: tuser = status, tdata = {count_out, slot_index, data_out, key_out}
// csr port: csr_wr_en/csr_wr_data write max_load_percent (reset 70)
// one item at a time. each probed slot takes a tag ram read, then a compare,
// and a key compare follows when its tag matches. lookup and remove fetch
// key and data from the ram when they report a slot. iterate walks the slots
// in order and fetches key and data when an occupied slot is found. unknown
// modes and iterate-next past the end go straight to the output state.
// after reset the tag ram is cleared one slot per cycle, all TABLE_SLOTS slots,
// during which req_tready is low. the result waits in the output register
// while rsp_tready is low; a new request is taken the cycle after it transfers.
module linear_probe_hash_table_core #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_BITS    = 32,
   parameter int DATA_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // mode
   input  logic [95:0]  req_tdata,   // key_in, hash_in, data_in
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [87:0]  rsp_tdata,   // key_out, data_out, slot_index, count_out, pad
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int HB = lpht_pkg::HASH_BITS;

   lpht_pkg::state_type state_ff, state_in;

   logic [6:0]              load_ff;
   logic [2:0]              mode_ff, mode_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [HB-1:0]           tag_ff, tag_in;
   logic [DATA_BITS-1:0]    data_ff, data_in;
   logic [AW-1:0]           idx_ff, idx_in, start_ff, start_in, tomb_ff, tomb_in;
   logic                    seen_ff, seen_in, first_ff, first_in;
   logic [CW-1:0]           count_ff, count_in, walk_ff, walk_in;
   logic [2:0]              st_ff, st_in;
   logic                    slot_ff, slot_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [2:0]              rst_ff, rst_in;
   logic [KEY_BITS-1:0]     okey_ff, okey_in;
   logic [DATA_BITS-1:0]    odata_ff, odata_in;
   logic                    ovalid_ff, ovalid_in;

   logic                    tw_en, kd_en;
   logic [AW-1:0]           tw_addr, t_raddr, kd_raddr;
   logic [HB-1:0]           tw_data, t_rdata;
   logic [KEY_BITS-1:0]     k_rdata;
   logic [DATA_BITS-1:0]    d_rdata;

   logic [HB-1:0]           hash_w, tag_adj;
   logic [AW-1:0]           idx_next;
   logic [6:0]              lim;
   logic [CW+7:0]           lhs, rhs;

   lpht_ram #(.WIDTH(HB), .DEPTH(TABLE_SLOTS)) u_tag (
      .clock(clock), .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_data),
      .rd_addr(t_raddr), .rd_data(t_rdata));
   lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_SLOTS)) u_key (
      .clock(clock), .wr_en(kd_en), .wr_addr(pos_ff), .wr_data(key_ff),
      .rd_addr(kd_raddr), .rd_data(k_rdata));
   lpht_ram #(.WIDTH(DATA_BITS), .DEPTH(TABLE_SLOTS)) u_data (
      .clock(clock), .wr_en(kd_en), .wr_addr(pos_ff), .wr_data(data_ff),
      .rd_addr(kd_raddr), .rd_data(d_rdata));

   assign hash_w   = req_tdata[63:32];
   assign tag_adj  = (hash_w < 32'd2) ? (hash_w | lpht_pkg::HASH_TOP) : hash_w;
   assign idx_next = (idx_ff == AW'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
   assign lim      = (load_ff > lpht_pkg::LOAD_CEILING) ? lpht_pkg::LOAD_CEILING : load_ff;
   assign lhs      = (CW+8)'(count_ff + 1'b1) * (CW+8)'(lpht_pkg::PERCENT);
   assign rhs      = (CW+8)'(lim) * (CW+8)'(TABLE_SLOTS);
   assign kd_raddr = pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lpht_pkg::S_CLEAR;
         load_ff   <= lpht_pkg::LOAD_RESET;
         count_ff  <= '0;
         walk_ff   <= '0;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_wr_en) begin
            load_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         walk_ff   <= walk_in;
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
      mode_ff  <= mode_in;  key_ff   <= key_in;   tag_ff  <= tag_in;
      data_ff  <= data_in;  start_ff <= start_in; tomb_ff <= tomb_in;
      seen_ff  <= seen_in;  first_ff <= first_in; st_ff   <= st_in;
      slot_ff  <= slot_in;  pos_ff   <= pos_in;   rst_ff  <= rst_in;
      okey_ff  <= okey_in;  odata_ff <= odata_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; key_in = key_ff; tag_in = tag_ff; data_in = data_ff;
      idx_in = idx_ff; start_in = start_ff; tomb_in = tomb_ff; seen_in = seen_ff;
      first_in = first_ff; count_in = count_ff; walk_in = walk_ff;
      st_in = st_ff; slot_in = slot_ff; pos_in = pos_ff; rst_in = rst_ff;
      okey_in = okey_ff; odata_in = odata_ff; ovalid_in = ovalid_ff;
      tw_en = 1'b0; tw_addr = idx_ff; tw_data = lpht_pkg::TAG_EMPTY;
      kd_en = 1'b0; t_raddr = idx_ff;
      req_tready = 1'b0;
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         lpht_pkg::S_CLEAR: begin
            tw_en = 1'b1;
            idx_in = idx_next;
            if (idx_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         lpht_pkg::S_IDLE: begin
            req_tready = !ovalid_ff;
            if (req_tvalid && !ovalid_ff) begin
               mode_in  = req_tuser;
               key_in   = KEY_BITS'(req_tdata[31:0]);
               tag_in   = tag_adj;
               data_in  = DATA_BITS'(req_tdata[95:64]);
               idx_in   = AW'(tag_adj % TABLE_SLOTS);
               start_in = AW'(tag_adj % TABLE_SLOTS);
               seen_in  = 1'b0;
               first_in = 1'b1;
               slot_in  = 1'b0;
               pos_in   = '0;
               state_in = lpht_pkg::S_READ;
               if (req_tuser == lpht_pkg::MODE_ITER_FIRST) begin
                  walk_in = '0;
                  idx_in  = '0;
               end else if (req_tuser == lpht_pkg::MODE_ITER_NEXT) begin
                  idx_in = AW'(walk_ff);
               end
               if (req_tuser > lpht_pkg::MODE_ITER_NEXT) begin
                  st_in = lpht_pkg::ST_MISS;
                  state_in = lpht_pkg::S_OUT;
               end else if (req_tuser == lpht_pkg::MODE_ITER_NEXT
                            && walk_ff >= CW'(TABLE_SLOTS)) begin
                  st_in = lpht_pkg::ST_END;
                  state_in = lpht_pkg::S_OUT;
               end
            end
         end
         lpht_pkg::S_READ: begin
            state_in = lpht_pkg::S_CHECK;
         end
         lpht_pkg::S_CHECK: begin
            state_in = lpht_pkg::S_READ;
            first_in = 1'b0;
            if (mode_ff == lpht_pkg::MODE_ITER_FIRST
                || mode_ff == lpht_pkg::MODE_ITER_NEXT) begin
               walk_in = walk_ff + 1'b1;
               idx_in  = idx_next;
               if (t_rdata > lpht_pkg::TAG_TOMB) begin
                  st_in = lpht_pkg::ST_FOUND; slot_in = 1'b1; pos_in = idx_ff;
                  state_in = lpht_pkg::S_FETCH;
               end else if (walk_ff == CW'(TABLE_SLOTS - 1)) begin
                  st_in = lpht_pkg::ST_END;
                  state_in = lpht_pkg::S_OUT;
               end
            end else if (!first_ff && idx_ff == start_ff) begin
               pos_in = tomb_ff;
               rst_in = lpht_pkg::ST_MISS;
               state_in = lpht_pkg::S_WRITE;
               slot_in = seen_ff;
            end else if (t_rdata == lpht_pkg::TAG_EMPTY) begin
               pos_in = seen_ff ? tomb_ff : idx_ff;
               slot_in = 1'b1;
               rst_in = lpht_pkg::ST_MISS;
               state_in = lpht_pkg::S_WRITE;
            end else begin
               if (t_rdata == lpht_pkg::TAG_TOMB) begin
                  if (!seen_ff) begin
                     seen_in = 1'b1; tomb_in = idx_ff;
                  end
                  idx_in = idx_next;
               end else if (t_rdata != tag_ff) begin
                  idx_in = idx_next;
               end else begin
                  pos_in = idx_ff;
                  rst_in = lpht_pkg::ST_FOUND;
                  state_in = lpht_pkg::S_FETCH;
                  st_in = lpht_pkg::ST_FOUND;
                  slot_in = 1'b0;
               end
            end
            if (state_in == lpht_pkg::S_READ) begin
               t_raddr = idx_in;
            end
         end
         lpht_pkg::S_FETCH: begin
            // tag matched for lookup, enter or remove: key ram data now valid, compare key; else latch key/data out
            if (mode_ff <= lpht_pkg::MODE_REMOVE && rst_ff == lpht_pkg::ST_FOUND
                && st_ff == lpht_pkg::ST_FOUND && !slot_ff) begin
               state_in = lpht_pkg::S_WRITE;
               slot_in = (k_rdata == key_ff);
               rst_in = (k_rdata == key_ff) ? lpht_pkg::ST_FOUND : lpht_pkg::ST_MISS;
               if (k_rdata != key_ff) begin
                  idx_in = idx_next;
                  slot_in = 1'b0;
                  state_in = lpht_pkg::S_READ;
                  st_in = lpht_pkg::ST_MISS;
                  t_raddr = idx_next;
                  if (idx_next == start_ff) begin
                     pos_in = tomb_ff;
                     slot_in = seen_ff;
                     state_in = lpht_pkg::S_WRITE;
                  end
               end
            end else begin
               okey_in = k_rdata; odata_in = d_rdata;
               state_in = lpht_pkg::S_OUT;
            end
         end
         lpht_pkg::S_WRITE: begin
            state_in = lpht_pkg::S_OUT;
            okey_in = key_ff; odata_in = data_ff;
            case (mode_ff)
               lpht_pkg::MODE_LOOKUP: begin
                  if (rst_ff == lpht_pkg::ST_FOUND) begin
                     st_in = lpht_pkg::ST_FOUND; state_in = lpht_pkg::S_FETCH;
                     slot_in = 1'b1; rst_in = lpht_pkg::ST_MISS;
                  end else begin
                     st_in = lpht_pkg::ST_MISS; slot_in = 1'b0;
                  end
               end
               lpht_pkg::MODE_ENTER: begin
                  if (rst_ff == lpht_pkg::ST_FOUND) begin
                     kd_en = 1'b1; tw_en = 1'b1; tw_addr = pos_ff; tw_data = tag_ff;
                     st_in = lpht_pkg::ST_UPDATED;
                  end else if (!slot_ff || lhs > rhs) begin
                     st_in = lpht_pkg::ST_FULL; slot_in = 1'b0;
                  end else begin
                     kd_en = 1'b1; tw_en = 1'b1; tw_addr = pos_ff; tw_data = tag_ff;
                     count_in = count_ff + 1'b1;
                     st_in = lpht_pkg::ST_INSERTED;
                  end
               end
               default: begin
                  if (rst_ff == lpht_pkg::ST_FOUND) begin
                     tw_en = 1'b1; tw_addr = pos_ff; tw_data = lpht_pkg::TAG_TOMB;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     st_in = lpht_pkg::ST_REMOVED; state_in = lpht_pkg::S_FETCH;
                     rst_in = lpht_pkg::ST_MISS; slot_in = 1'b1;
                  end else begin
                     st_in = lpht_pkg::ST_MISS; slot_in = 1'b0;
                  end
               end
            endcase
         end
         lpht_pkg::S_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               state_in = lpht_pkg::S_IDLE;
               if (!slot_ff) begin
                  okey_in = '0; odata_in = '0; pos_in = '0;
               end
            end
         end
         default: begin
            state_in = lpht_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {7'd0, 9'(count_ff), 8'(pos_ff), 32'(odata_ff), 32'(okey_ff)};

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

   localparam int SLOTS = 256;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int TAIL_CYCLES = 1200;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key;
      logic [31:0] data;
      logic [7:0]  slot;
      logic [8:0]  count;
   } answer_type;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] data;
      bit          typed;
      answer_type  ans;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [2:0] req_tuser = '0;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [2:0] rsp_tuser;
   logic [87:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [6:0] csr_wr_data = '0;

   linear_probe_hash_table_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // shadow table
   logic [31:0] tag_mem [SLOTS];
   logic [31:0] key_mem [SLOTS];
   logic [31:0] data_mem [SLOTS];
   int unsigned live_count;
   int unsigned walk_pos;
   logic [6:0] load_limit;

   answer_type pending_q[$];
   int errors = 0;
   longint cycles = 0;
   int rsp_wait = 0;

   // keys in use for well-formed traffic
   logic [31:0] pool_key [16];
   logic [31:0] pool_hash [16];

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic answer_type mk(logic [2:0] st, bit with_slot, int pos);
      answer_type a;
      a.status = st;
      a.key = with_slot ? key_mem[pos] : '0;
      a.data = with_slot ? data_mem[pos] : '0;
      a.slot = with_slot ? pos[7:0] : '0;
      a.count = live_count[8:0];
      return a;
   endfunction

   function automatic answer_type table_step(logic [2:0] mode, logic [31:0] key,
                                             logic [31:0] hash, logic [31:0] data);
      logic [31:0] t;
      int idx, start, tomb, pos;
      bit seen_tomb, hit, have, done;
      int unsigned lim;
      answer_type a;
      t = hash;
      if (t < 2) t = t + lpht_pkg::HASH_TOP;
      idx = t % SLOTS;
      start = idx;
      seen_tomb = 0; tomb = 0; hit = 0; have = 0; done = 0; pos = 0;
      do begin
         if (tag_mem[idx] == lpht_pkg::TAG_EMPTY) begin
            pos = seen_tomb ? tomb : idx;
            have = 1;
            done = 1;
         end else if (tag_mem[idx] == lpht_pkg::TAG_TOMB) begin
            if (!seen_tomb) begin
               seen_tomb = 1;
               tomb = idx;
            end
         end else if (tag_mem[idx] == t && key_mem[idx] == key) begin
            pos = idx;
            have = 1;
            hit = 1;
            done = 1;
         end
         if (!done) idx = (idx + 1) % SLOTS;
      end while (!done && idx != start);
      if (!done) begin
         pos = tomb;
         have = seen_tomb;
      end
      lim = 32'((load_limit > lpht_pkg::LOAD_CEILING) ? lpht_pkg::LOAD_CEILING : load_limit);
      case (mode)
         lpht_pkg::MODE_LOOKUP:
            a = mk(hit ? lpht_pkg::ST_FOUND : lpht_pkg::ST_MISS, hit, pos);
         lpht_pkg::MODE_ENTER: begin
            if (hit || (have && !((live_count + 1) * lpht_pkg::PERCENT > lim * SLOTS)))
            begin
               key_mem[pos] = key;
               data_mem[pos] = data;
               tag_mem[pos] = t;
               if (!hit) live_count++;
               a = mk(hit ? lpht_pkg::ST_UPDATED : lpht_pkg::ST_INSERTED, 1, pos);
            end else
               a = mk(lpht_pkg::ST_FULL, 0, 0);
         end
         lpht_pkg::MODE_REMOVE: begin
            if (hit) begin
               tag_mem[pos] = lpht_pkg::TAG_TOMB;
               if (live_count > 0) live_count--;
               a = mk(lpht_pkg::ST_REMOVED, 1, pos);
            end else
               a = mk(lpht_pkg::ST_MISS, 0, 0);
         end
         lpht_pkg::MODE_ITER_FIRST, lpht_pkg::MODE_ITER_NEXT: begin
            if (mode == lpht_pkg::MODE_ITER_FIRST) walk_pos = 0;
            a = mk(lpht_pkg::ST_END, 0, 0);
            while (walk_pos < SLOTS) begin
               walk_pos++;
               if (tag_mem[walk_pos-1] > lpht_pkg::TAG_TOMB) begin
                  a = mk(lpht_pkg::ST_FOUND, 1, walk_pos - 1);
                  break;
               end
            end
         end
         default: a = mk(lpht_pkg::ST_MISS, 0, 0);
      endcase
      return a;
   endfunction

   task automatic send_item(logic [2:0] mode, logic [31:0] key, logic [31:0] hash,
                            logic [31:0] data, bit typed, answer_type ans);
      answer_type a;
      int w;
      w = $urandom_range(0, 10);
      if (w != 0) begin
         req_tvalid <= 0;
         repeat (w) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {data, hash, key};
      do @(posedge clock); while (!req_tready);
      a = table_step(mode, key, hash, data);
      if (typed && a != ans) begin
         errors++;
         if (errors <= 10)
            $display("table row mismatch: typed %h predicted %h", ans, a);
      end
      pending_q.push_back(a);
   endtask

   task automatic write_limit(logic [6:0] v);
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      load_limit = v;
   endtask

   // result side
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[71:64],
                rsp_tdata[80:72]};
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer %h", got);
         end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: st %0d/%0d key %h/%h data %h/%h slot %0d/%0d cnt %0d/%0d",
                     want.status, got.status, want.key, got.key, want.data, got.data,
                     want.slot, got.slot, want.count, got.count);
            end
         end
      end
   end

   // result stall drawn per transfer
   always @(posedge clock) begin
      int w;
      if (reset || (rsp_tvalid && rsp_tready)) begin
         w = $urandom_range(0, 10);
         rsp_wait <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_tvalid && rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end
   end

   stim_row_type rows [$];

   function automatic answer_type lit(logic [2:0] st, logic [31:0] k, logic [31:0] d,
                                      logic [7:0] s, logic [8:0] c);
      answer_type a;
      a.status = st; a.key = k; a.data = d; a.slot = s; a.count = c;
      return a;
   endfunction

   task automatic add_row(logic [2:0] m, logic [31:0] k, logic [31:0] h, logic [31:0] d,
                          bit typed, answer_type a);
      stim_row_type r;
      r.mode = m; r.key = k; r.hash = h; r.data = d; r.typed = typed; r.ans = a;
      rows.push_back(r);
   endtask

   task automatic random_phase(int n, int key_span);
      int sel, p;
      logic [2:0] m;
      logic [31:0] k, h, d;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, key_span - 1);
         sel = $urandom_range(0, 99);
         k = pool_key[p]; h = pool_hash[p]; d = $urandom;
         if (sel < 40) m = lpht_pkg::MODE_ENTER;
         else if (sel < 60) m = lpht_pkg::MODE_LOOKUP;
         else if (sel < 78) m = lpht_pkg::MODE_REMOVE;
         else if (sel < 82) m = lpht_pkg::MODE_ITER_FIRST;
         else if (sel < 90) m = lpht_pkg::MODE_ITER_NEXT;
         else if (sel < 93) m = 3'($urandom_range(5, 7));
         else begin
            m = 3'($urandom_range(0, 2));
            k = $urandom;
            h = $urandom;
         end
         send_item(m, k, h, d, 0, '0);
      end
   endtask

   answer_type none;

   initial begin
      none = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tag_mem[i] = lpht_pkg::TAG_EMPTY; key_mem[i] = '0; data_mem[i] = '0;
      end
      live_count = 0; walk_pos = 0; load_limit = lpht_pkg::LOAD_RESET;
      repeat (12) @(posedge clock);
      reset <= 0;

      add_row(lpht_pkg::MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1,
              lit(lpht_pkg::ST_MISS, 0, 0, 0, 0));
      add_row(lpht_pkg::MODE_ITER_FIRST, 32'h0, 32'h0, 32'h0, 1,
              lit(lpht_pkg::ST_END, 0, 0, 0, 0));
      add_row(lpht_pkg::MODE_ITER_NEXT, 32'h0, 32'h0, 32'h0, 1,
              lit(lpht_pkg::ST_END, 0, 0, 0, 0));
      add_row(lpht_pkg::MODE_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              lit(lpht_pkg::ST_INSERTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1));
      add_row(lpht_pkg::MODE_ENTER, 32'h0, 32'h0, 32'h0, 1,
              lit(lpht_pkg::ST_INSERTED, 0, 0, 0, 2));
      add_row(lpht_pkg::MODE_ENTER, 32'h1, 32'h1, 32'hA5A5_5A5A, 1,
              lit(lpht_pkg::ST_INSERTED, 1, 32'hA5A5_5A5A, 1, 3));
      add_row(lpht_pkg::MODE_LOOKUP, 32'h0, 32'h8000_0000, 32'h0, 0, none);
      add_row(lpht_pkg::MODE_ENTER, 32'h0, 32'h0, 32'h1234_5678, 1,
              lit(lpht_pkg::ST_UPDATED, 0, 32'h1234_5678, 0, 3));
      add_row(lpht_pkg::MODE_ENTER, 32'h5555_5555, 32'h0000_01FF, 32'hAAAA_AAAA, 0, none);
      add_row(lpht_pkg::MODE_ENTER, 32'hAAAA_AAAA, 32'h0000_02FF, 32'h5555_5555, 0, none);
      add_row(lpht_pkg::MODE_LOOKUP, 32'hAAAA_AAAA, 32'h0000_02FF, 32'h0, 0, none);
      add_row(lpht_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, none);
      add_row(lpht_pkg::MODE_LOOKUP, 32'hAAAA_AAAA, 32'h0000_02FF, 32'h0, 0, none);
      add_row(lpht_pkg::MODE_REMOVE, 32'h7, 32'h7, 32'h0, 1,
              lit(lpht_pkg::ST_MISS, 0, 0, 0, 4));
      add_row(lpht_pkg::MODE_ENTER, 32'h9, 32'hFF, 32'h9, 0, none);
      add_row(3'd5, 32'h1, 32'h1, 32'h1, 1, lit(lpht_pkg::ST_MISS, 0, 0, 0, 5));
      add_row(3'd7, 32'h0, 32'h0, 32'h0, 1, lit(lpht_pkg::ST_MISS, 0, 0, 0, 5));
      add_row(lpht_pkg::MODE_ITER_FIRST, 32'h0, 32'h0, 32'h0, 0, none);
      for (int i = 0; i < 6; i++)
         add_row(lpht_pkg::MODE_ITER_NEXT, 32'h0, 32'h0, 32'h0, 0, none);
      foreach (rows[i])
         send_item(rows[i].mode, rows[i].key, rows[i].hash, rows[i].data,
                   rows[i].typed, rows[i].ans);

      // zero limit refuses new keys but updates existing ones
      write_limit(7'd0);
      send_item(lpht_pkg::MODE_ENTER, 32'h0, 32'h0, 32'hDEAD_BEEF, 0, none);
      send_item(lpht_pkg::MODE_ENTER, 32'h42, 32'h42, 32'h1, 1,
                lit(lpht_pkg::ST_FULL, 0, 0, 0, 5));

      for (int i = 0; i < 16; i++) begin
         pool_key[i] = $urandom;
         pool_hash[i] = (i < 4) ? 32'($urandom_range(0, 1))
                                : (($urandom() << 4) | 32'(i % 3));
      end
      write_limit(7'd127);
      random_phase(200, 16);
      write_limit(7'd1);
      random_phase(100, 16);
      write_limit(7'd99);
      for (int r = 0; r < 3; r++) begin
         for (int i = 0; i < 16; i++) begin
            pool_key[i] = $urandom;
            pool_hash[i] = $urandom & 32'hFFFF_FF0F;
         end
         random_phase(200, 16);
      end
      write_limit(7'd20);
      random_phase(200, 16);
      write_limit(7'd70);
      random_phase(200, 16);
      req_tvalid <= 0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
